// ===== sv/obstacle_steering_decider_defines.svh =====
// assertion macros shared by the checker of obstacle_steering_decider
// expects signals clk and rst_n in the scope of each use
`ifndef OBSTACLE_STEERING_DECIDER_DEFINES_SVH
`define OBSTACLE_STEERING_DECIDER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define OSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define OSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/osd_pkg.sv =====
// shared types and constants of the obstacle steering decider
// no dependencies
package osd_pkg;

  typedef enum logic [3:0] {
    ST_STOP         = 4'd0,
    ST_REVERSE      = 4'd1,
    ST_FULL_LEFT    = 4'd2,
    ST_FULL_RIGHT   = 4'd3,
    ST_MID_LEFT     = 4'd4,
    ST_MID_RIGHT    = 4'd5,
    ST_SLIGHT_LEFT  = 4'd6,
    ST_SLIGHT_RIGHT = 4'd7,
    ST_STRAIGHT     = 4'd8
  } steer_state_t;

  typedef enum logic [2:0] {
    REQ_SAMPLE = 3'd0,
    REQ_GEO    = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  localparam logic [1:0] SPEED_HALT  = 2'd0;
  localparam logic [1:0] SPEED_ESTOP = 2'd1;
  localparam logic [1:0] SPEED_CRAWL = 2'd2;

  localparam logic [2:0] STEER_CENTER     = 3'd0;
  localparam logic [2:0] STEER_SOFT_LEFT  = 3'd1;
  localparam logic [2:0] STEER_SOFT_RIGHT = 3'd2;
  localparam logic [2:0] STEER_HALF_LEFT  = 3'd3;
  localparam logic [2:0] STEER_HALF_RIGHT = 3'd4;
  localparam logic [2:0] STEER_HARD_LEFT  = 3'd5;
  localparam logic [2:0] STEER_HARD_RIGHT = 3'd6;

  localparam logic [2:0] ZONE_NONE  = 3'd0;
  localparam logic [2:0] ZONE_ONE   = 3'd1;
  localparam logic [2:0] ZONE_TWO   = 3'd2;
  localparam logic [2:0] ZONE_THREE = 3'd3;
  localparam logic [2:0] ZONE_FOUR  = 3'd4;

  localparam logic [2:0] CFG_ZONE_BASE   = 3'd0;
  localparam logic [2:0] CFG_ZONE_ONE    = 3'd1;
  localparam logic [2:0] CFG_ZONE_TWO    = 3'd2;
  localparam logic [2:0] CFG_ZONE_THREE  = 3'd3;
  localparam logic [2:0] CFG_ZONE_FOUR   = 3'd4;
  localparam logic [2:0] CFG_BACK_NEAR   = 3'd5;
  localparam logic [2:0] CFG_ARRIVE_DIST = 3'd6;

  localparam logic [7:0]  RST_ZONE_BASE   = 8'd0;
  localparam logic [7:0]  RST_ZONE_ONE    = 8'd20;
  localparam logic [7:0]  RST_ZONE_TWO    = 8'd40;
  localparam logic [7:0]  RST_ZONE_THREE  = 8'd60;
  localparam logic [7:0]  RST_ZONE_FOUR   = 8'd255;
  localparam logic [7:0]  RST_BACK_NEAR   = 8'd20;
  localparam logic [15:0] RST_ARRIVE_DIST = 16'd30;

  // heading bands used on a clear path
  localparam logic signed [7:0] HEAD_NEAR = 8'sd6;
  localparam logic signed [7:0] HEAD_FAR  = 8'sd10;

  // heading error fold
  localparam logic signed [9:0] GEO_FOLD = 10'sd10;
  localparam logic signed [9:0] GEO_WRAP = 10'sd20;

  typedef struct packed {
    logic [7:0]  zone_base;
    logic [7:0]  zone_one_limit;
    logic [7:0]  zone_two_limit;
    logic [7:0]  zone_three_limit;
    logic [7:0]  zone_four_limit;
    logic [7:0]  back_near_limit;
    logic [15:0] arrive_distance;
  } osd_cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  left_dist;
    logic [7:0]  middle_dist;
    logic [7:0]  right_dist;
    logic [7:0]  back_dist;
    logic        geo_ok;
    logic [7:0]  compass_angle;
    logic [7:0]  bearing_angle;
    logic [15:0] dest_distance;
  } osd_item_t;

  typedef struct packed {
    logic       drive_dir;
    logic [1:0] drive_speed;
    logic [2:0] steer;
    logic [3:0] steer_state;
  } osd_result_t;

endpackage

// ===== sv/osd_quant.sv =====
// distance to zone quantizer for one front sensor
// depends on osd_pkg
module osd_quant (
  input  logic [7:0]     meas,
  input  osd_pkg::osd_cfg_t cfg,
  input  logic [2:0]     old_zone,
  output logic [2:0]     zone
);

  logic [8:0] meas_p1;
  logic       in_one;
  logic       in_two;
  logic       in_three;
  logic       in_four;

  // lower bound of zones two to four is one below the previous limit
  assign meas_p1  = {1'b0, meas} + 9'd1;
  assign in_one   = (meas >= cfg.zone_base) && (meas <= cfg.zone_one_limit);
  assign in_two   = (meas_p1 >= {1'b0, cfg.zone_one_limit}) && (meas <= cfg.zone_two_limit);
  assign in_three = (meas_p1 >= {1'b0, cfg.zone_two_limit}) && (meas <= cfg.zone_three_limit);
  assign in_four  = (meas_p1 >= {1'b0, cfg.zone_three_limit}) && (meas <= cfg.zone_four_limit);

  always_comb begin
    priority if (in_one) begin
      zone = osd_pkg::ZONE_ONE;
    end else if (in_two) begin
      zone = osd_pkg::ZONE_TWO;
    end else if (in_three) begin
      zone = osd_pkg::ZONE_THREE;
    end else if (in_four) begin
      zone = osd_pkg::ZONE_FOUR;
    end else begin
      zone = old_zone;
    end
  end

endmodule

// ===== sv/osd_cfg_regs.sv =====
// configuration register file of the obstacle steering decider
// depends on osd_pkg
module osd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output osd_pkg::osd_cfg_t cfg
);

  osd_pkg::osd_cfg_t cfg_r;
  osd_pkg::osd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        osd_pkg::CFG_ZONE_BASE:   cfg_nxt.zone_base        = cfg_wdata[7:0];
        osd_pkg::CFG_ZONE_ONE:    cfg_nxt.zone_one_limit   = cfg_wdata[7:0];
        osd_pkg::CFG_ZONE_TWO:    cfg_nxt.zone_two_limit   = cfg_wdata[7:0];
        osd_pkg::CFG_ZONE_THREE:  cfg_nxt.zone_three_limit = cfg_wdata[7:0];
        osd_pkg::CFG_ZONE_FOUR:   cfg_nxt.zone_four_limit  = cfg_wdata[7:0];
        osd_pkg::CFG_BACK_NEAR:   cfg_nxt.back_near_limit  = cfg_wdata[7:0];
        osd_pkg::CFG_ARRIVE_DIST: cfg_nxt.arrive_distance  = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_base        <= osd_pkg::RST_ZONE_BASE;
      cfg_r.zone_one_limit   <= osd_pkg::RST_ZONE_ONE;
      cfg_r.zone_two_limit   <= osd_pkg::RST_ZONE_TWO;
      cfg_r.zone_three_limit <= osd_pkg::RST_ZONE_THREE;
      cfg_r.zone_four_limit  <= osd_pkg::RST_ZONE_FOUR;
      cfg_r.back_near_limit  <= osd_pkg::RST_BACK_NEAR;
      cfg_r.arrive_distance  <= osd_pkg::RST_ARRIVE_DIST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/osd_decide.sv =====
// steering state, heading and gating registers with the decision chain
// depends on osd_pkg and osd_quant
module osd_decide (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc_en,
  input  osd_pkg::osd_item_t   item,
  input  osd_pkg::osd_cfg_t    cfg,
  output logic                 res_valid,
  output osd_pkg::osd_result_t res
);

  logic [2:0]            left_zone_r,  left_zone_nxt;
  logic [2:0]            middle_zone_r, middle_zone_nxt;
  logic [2:0]            right_zone_r, right_zone_nxt;
  osd_pkg::steer_state_t cur_state_r,  cur_state_nxt;
  osd_pkg::steer_state_t prev_state_r, prev_state_nxt;
  logic [7:0]            head_err_r,   head_err_nxt;
  logic                  arrived_r,    arrived_nxt;
  logic                  rev_left_r,   rev_left_nxt;
  logic                  paused_r,     paused_nxt;
  logic                  fix_valid_r,  fix_valid_nxt;

  logic [2:0]            lz_q, mz_q, rz_q;
  logic                  back_near;
  logic                  front_block;
  logic signed [7:0]     head;
  logic signed [9:0]     ang_diff;
  logic signed [9:0]     head_fold;
  osd_pkg::steer_state_t pick;
  logic                  pick_rev_left;

  osd_quant u_quant_left (
    .meas(item.left_dist), .cfg(cfg), .old_zone(left_zone_r), .zone(lz_q)
  );
  osd_quant u_quant_middle (
    .meas(item.middle_dist), .cfg(cfg), .old_zone(middle_zone_r), .zone(mz_q)
  );
  osd_quant u_quant_right (
    .meas(item.right_dist), .cfg(cfg), .old_zone(right_zone_r), .zone(rz_q)
  );

  assign back_near   = item.back_dist <= cfg.back_near_limit;
  assign front_block = (mz_q == osd_pkg::ZONE_ONE) ||
                       ((lz_q == osd_pkg::ZONE_ONE) && (rz_q == osd_pkg::ZONE_ONE));
  assign head        = $signed(head_err_r);

  // steering priority chain on the fresh zones
  always_comb begin
    pick          = cur_state_r;
    pick_rev_left = rev_left_r;
    priority if (((prev_state_r == osd_pkg::ST_REVERSE) ||
                  (prev_state_r == osd_pkg::ST_STOP)) && back_near) begin
      pick = osd_pkg::ST_STOP;
    end else if (front_block && back_near) begin
      pick = osd_pkg::ST_STOP;
    end else if (front_block) begin
      pick_rev_left = !((lz_q > osd_pkg::ZONE_ONE) && (rz_q == osd_pkg::ZONE_ONE));
      pick          = osd_pkg::ST_REVERSE;
    end else if (lz_q == osd_pkg::ZONE_ONE) begin
      pick = osd_pkg::ST_FULL_RIGHT;
    end else if (rz_q == osd_pkg::ZONE_ONE) begin
      pick = osd_pkg::ST_FULL_LEFT;
    end else if ((mz_q == osd_pkg::ZONE_TWO) && (lz_q > rz_q)) begin
      pick = osd_pkg::ST_MID_LEFT;
    end else if (mz_q == osd_pkg::ZONE_TWO) begin
      pick = osd_pkg::ST_MID_RIGHT;
    end else if ((mz_q == osd_pkg::ZONE_THREE) && (lz_q >= osd_pkg::ZONE_TWO) &&
                 (lz_q < osd_pkg::ZONE_FOUR) && (mz_q <= rz_q)) begin
      pick = osd_pkg::ST_SLIGHT_RIGHT;
    end else if ((mz_q == osd_pkg::ZONE_THREE) && (rz_q >= osd_pkg::ZONE_TWO) &&
                 (rz_q < osd_pkg::ZONE_FOUR) && (mz_q < lz_q)) begin
      pick = osd_pkg::ST_SLIGHT_LEFT;
    end else if (mz_q == osd_pkg::ZONE_FOUR) begin
      // clear path, steer on heading error
      priority if ((head < 8'sd0) && (head >= -osd_pkg::HEAD_NEAR)) begin
        pick = osd_pkg::ST_MID_RIGHT;
      end else if ((head < 8'sd0) && (head >= -osd_pkg::HEAD_FAR)) begin
        pick          = osd_pkg::ST_REVERSE;
        pick_rev_left = 1'b1;
      end else if ((head > 8'sd0) && (head <= osd_pkg::HEAD_NEAR)) begin
        pick = osd_pkg::ST_MID_LEFT;
      end else if ((head > 8'sd0) && (head <= osd_pkg::HEAD_FAR)) begin
        pick          = osd_pkg::ST_REVERSE;
        pick_rev_left = 1'b0;
      end else if (head == 8'sd0) begin
        pick = osd_pkg::ST_STRAIGHT;
      end else begin
        pick = cur_state_r;
      end
    end else begin
      pick = osd_pkg::ST_STRAIGHT;
    end
  end

  // wrapped heading error
  assign ang_diff = {{2{item.compass_angle[7]}}, item.compass_angle} -
                    {{2{item.bearing_angle[7]}}, item.bearing_angle};

  always_comb begin
    priority if (ang_diff <= -osd_pkg::GEO_FOLD) begin
      head_fold = ang_diff + osd_pkg::GEO_WRAP;
    end else if (ang_diff >= osd_pkg::GEO_FOLD) begin
      head_fold = osd_pkg::GEO_WRAP - ang_diff;
    end else begin
      head_fold = ang_diff;
    end
  end

  always_comb begin
    left_zone_nxt   = left_zone_r;
    middle_zone_nxt = middle_zone_r;
    right_zone_nxt  = right_zone_r;
    cur_state_nxt   = cur_state_r;
    prev_state_nxt  = prev_state_r;
    head_err_nxt    = head_err_r;
    arrived_nxt     = arrived_r;
    rev_left_nxt    = rev_left_r;
    paused_nxt      = paused_r;
    fix_valid_nxt   = fix_valid_r;
    if (proc_en) begin
      unique case (item.req_type)
        osd_pkg::REQ_SAMPLE: begin
          if (arrived_r) begin
            cur_state_nxt = osd_pkg::ST_STOP;
          end else begin
            left_zone_nxt   = lz_q;
            middle_zone_nxt = mz_q;
            right_zone_nxt  = rz_q;
            cur_state_nxt   = pick;
            prev_state_nxt  = pick;
            rev_left_nxt    = pick_rev_left;
          end
        end
        osd_pkg::REQ_GEO: begin
          fix_valid_nxt = item.geo_ok;
          head_err_nxt  = item.geo_ok ? head_fold[7:0] : 8'd0;
          arrived_nxt   = item.dest_distance <= cfg.arrive_distance;
        end
        osd_pkg::REQ_PAUSE:  paused_nxt = 1'b1;
        osd_pkg::REQ_RESUME: paused_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_zone_r   <= osd_pkg::ZONE_NONE;
      middle_zone_r <= osd_pkg::ZONE_NONE;
      right_zone_r  <= osd_pkg::ZONE_NONE;
      cur_state_r   <= osd_pkg::ST_STOP;
      prev_state_r  <= osd_pkg::ST_STOP;
      head_err_r    <= 8'd0;
      arrived_r     <= 1'b0;
      rev_left_r    <= 1'b0;
      paused_r      <= 1'b1;
      fix_valid_r   <= 1'b0;
    end else begin
      left_zone_r   <= left_zone_nxt;
      middle_zone_r <= middle_zone_nxt;
      right_zone_r  <= right_zone_nxt;
      cur_state_r   <= cur_state_nxt;
      prev_state_r  <= prev_state_nxt;
      head_err_r    <= head_err_nxt;
      arrived_r     <= arrived_nxt;
      rev_left_r    <= rev_left_nxt;
      paused_r      <= paused_nxt;
      fix_valid_r   <= fix_valid_nxt;
    end
  end

  // motor command for a tick
  assign res_valid = proc_en && (item.req_type == osd_pkg::REQ_TICK);

  always_comb begin
    res.drive_dir   = osd_pkg::DIR_FWD;
    res.drive_speed = osd_pkg::SPEED_HALT;
    res.steer       = osd_pkg::STEER_CENTER;
    res.steer_state = cur_state_r;
    if (fix_valid_r && !paused_r) begin
      res.drive_speed = osd_pkg::SPEED_CRAWL;
      unique case (cur_state_r)
        osd_pkg::ST_STOP: begin
          res.drive_dir   = osd_pkg::DIR_REV;
          res.drive_speed = osd_pkg::SPEED_ESTOP;
        end
        osd_pkg::ST_REVERSE: begin
          res.drive_dir = osd_pkg::DIR_REV;
          res.steer     = rev_left_r ? osd_pkg::STEER_HALF_LEFT : osd_pkg::STEER_HALF_RIGHT;
        end
        osd_pkg::ST_FULL_LEFT:    res.steer = osd_pkg::STEER_HARD_LEFT;
        osd_pkg::ST_FULL_RIGHT:   res.steer = osd_pkg::STEER_HARD_RIGHT;
        osd_pkg::ST_MID_LEFT:     res.steer = osd_pkg::STEER_HALF_LEFT;
        osd_pkg::ST_MID_RIGHT:    res.steer = osd_pkg::STEER_HALF_RIGHT;
        osd_pkg::ST_SLIGHT_LEFT:  res.steer = osd_pkg::STEER_SOFT_LEFT;
        osd_pkg::ST_SLIGHT_RIGHT: res.steer = osd_pkg::STEER_SOFT_RIGHT;
        osd_pkg::ST_STRAIGHT:     res.steer = osd_pkg::STEER_CENTER;
        default:                  res.drive_speed = osd_pkg::SPEED_HALT;
      endcase
    end
  end

endmodule

// ===== sv/obstacle_steering_decider.sv =====
// obstacle steering decider: input register, decision logic and result register
// depends on osd_pkg, osd_cfg_regs and osd_decide
//
// usage:
//   in_*  : one event per transfer, selected by in_req_type (sensor sample,
//           geo update, pause, resume, command tick); codes five to seven
//           are dropped without effect
//   out_* : one motor command per command tick, no transfer for other events
//   cfg_* : register write when cfg_we is high; write only while idle
// latency: a tick accepted at edge n shows its command on out_* after edge
//   n + 1 (input register at edge n, result register at edge n + 1)
// throughput: one event per cycle, set by the single decision pass between
//   the input register and the result register
// stall: while out_ready is low the result register holds; the input
//   register still takes one more event, then in_ready drops
// reset: zones cleared, steering state stop, block paused, no geo fix,
//   registers at their default values, both channels empty
module obstacle_steering_decider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_left_dist,
  input  logic [7:0]        in_middle_dist,
  input  logic [7:0]        in_right_dist,
  input  logic [7:0]        in_back_dist,
  input  logic              in_geo_ok,
  input  logic signed [7:0] in_compass_angle,
  input  logic signed [7:0] in_bearing_angle,
  input  logic [15:0]       in_dest_distance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_drive_dir,
  output logic [1:0]        out_drive_speed,
  output logic [2:0]        out_steer,
  output logic [3:0]        out_steer_state,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  osd_pkg::osd_cfg_t    cfg;
  osd_pkg::osd_item_t   item_r;
  osd_pkg::osd_result_t res;
  osd_pkg::osd_result_t out_res_r;
  logic                 item_valid_r, item_valid_nxt;
  logic                 out_valid_r,  out_valid_nxt;
  logic                 out_free;
  logic                 proc_en;
  logic                 in_xfer;
  logic                 res_valid;

  assign out_free = !out_valid_r || out_ready;
  assign proc_en  = item_valid_r && out_free;
  assign in_ready = !item_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  osd_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cfg(cfg)
  );

  osd_decide u_decide (
    .clk(clk), .rst_n(rst_n), .proc_en(proc_en), .item(item_r), .cfg(cfg),
    .res_valid(res_valid), .res(res)
  );

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_xfer) begin
      item_valid_nxt = 1'b1;
    end else if (proc_en) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? res_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.req_type      <= in_req_type;
      item_r.left_dist     <= in_left_dist;
      item_r.middle_dist   <= in_middle_dist;
      item_r.right_dist    <= in_right_dist;
      item_r.back_dist     <= in_back_dist;
      item_r.geo_ok        <= in_geo_ok;
      item_r.compass_angle <= in_compass_angle;
      item_r.bearing_angle <= in_bearing_angle;
      item_r.dest_distance <= in_dest_distance;
    end
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_dir   = out_res_r.drive_dir;
  assign out_drive_speed = out_res_r.drive_speed;
  assign out_steer       = out_res_r.steer;
  assign out_steer_state = out_res_r.steer_state;

endmodule

// ===== sv/osd_checker.sv =====
// port-level checker for obstacle_steering_decider, bound to the top level
// depends on osd_pkg and obstacle_steering_decider_defines.svh
`include "obstacle_steering_decider_defines.svh"

module osd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_drive_dir,
  input logic [1:0]        out_drive_speed,
  input logic [2:0]        out_steer,
  input logic [3:0]        out_steer_state
);

  // stalled command holds
  `OSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_drive_dir) && $stable(out_drive_speed) &&
    $stable(out_steer) && $stable(out_steer_state), "stalled command changed")

  // emergency stop only from the stop state, reversing straight
  `OSD_ASSERT_NOW(a_estop, out_valid && (out_drive_speed == osd_pkg::SPEED_ESTOP),
    (out_steer_state == osd_pkg::ST_STOP) && (out_drive_dir == osd_pkg::DIR_REV) &&
    (out_steer == osd_pkg::STEER_CENTER), "emergency stop inconsistent")

  // gated command is forward and straight
  `OSD_ASSERT_NOW(a_gated, out_valid && (out_drive_speed == osd_pkg::SPEED_HALT),
    (out_drive_dir == osd_pkg::DIR_FWD) && (out_steer == osd_pkg::STEER_CENTER),
    "stopped command not straight forward")

  // reversing state drives backward with a half turn
  `OSD_ASSERT_NOW(a_reverse,
    out_valid && (out_steer_state == osd_pkg::ST_REVERSE) &&
    (out_drive_speed == osd_pkg::SPEED_CRAWL),
    (out_drive_dir == osd_pkg::DIR_REV) &&
    ((out_steer == osd_pkg::STEER_HALF_LEFT) || (out_steer == osd_pkg::STEER_HALF_RIGHT)),
    "reverse command inconsistent")

endmodule

bind obstacle_steering_decider osd_checker u_osd_checker (.*);

// ===== tb/sv/obstacle_steering_decider_tb.sv =====
`timescale 1ns / 1ps
// testbench for obstacle_steering_decider: a directed event script, then random phases
// under several register settings; each command checked against a fixed value or the bench model
// depends on osd_pkg and the obstacle_steering_decider rtl
module obstacle_steering_decider_tb;
  import osd_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_SPARE    = 3'd7;
  localparam int GAP_PCT      = 7;
  localparam int PHASES       = 8;
  localparam int PHASE_EVENTS = 200;

  typedef struct {
    osd_item_t   ev;
    bit          fixed;
    osd_result_t cmd;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_req_type = REQ_SAMPLE;
  logic [7:0]        in_left_dist = '0;
  logic [7:0]        in_middle_dist = '0;
  logic [7:0]        in_right_dist = '0;
  logic [7:0]        in_back_dist = '0;
  logic              in_geo_ok = 1'b0;
  logic signed [7:0] in_compass_angle = '0;
  logic signed [7:0] in_bearing_angle = '0;
  logic [15:0]       in_dest_distance = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_drive_dir;
  logic [1:0]        out_drive_speed;
  logic [2:0]        out_steer;
  logic [3:0]        out_steer_state;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = CFG_ZONE_BASE;
  logic [15:0]       cfg_wdata = '0;

  // model of the decider
  osd_cfg_t cfg_m = osd_cfg_t'{RST_ZONE_BASE, RST_ZONE_ONE, RST_ZONE_TWO, RST_ZONE_THREE,
                               RST_ZONE_FOUR, RST_BACK_NEAR, RST_ARRIVE_DIST};
  logic [2:0]        zone_l = ZONE_NONE;
  logic [2:0]        zone_m = ZONE_NONE;
  logic [2:0]        zone_r = ZONE_NONE;
  steer_state_t      state_now = ST_STOP;
  steer_state_t      state_prev = ST_STOP;
  logic signed [7:0] head_err = '0;
  logic              at_dest = 1'b0;
  logic              rev_turn_left = 1'b0;
  logic              on_hold = 1'b1;
  logic              fix_ok = 1'b0;

  osd_result_t pending_cmds[$];
  script_row_t script[$];
  osd_result_t seen_cmd, due_cmd;
  int n_events = 0, n_cmds = 0, n_settings = 1, bad = 0;
  bit gaps_on = 1'b1;

  obstacle_steering_decider uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_left_dist     (in_left_dist),
    .in_middle_dist   (in_middle_dist),
    .in_right_dist    (in_right_dist),
    .in_back_dist     (in_back_dist),
    .in_geo_ok        (in_geo_ok),
    .in_compass_angle (in_compass_angle),
    .in_bearing_angle (in_bearing_angle),
    .in_dest_distance (in_dest_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_dir    (out_drive_dir),
    .out_drive_speed  (out_drive_speed),
    .out_steer        (out_steer),
    .out_steer_state  (out_steer_state),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [2:0] zone_of(input logic [7:0] d, input logic [2:0] old);
    int v, l1, l2, l3, l4;
    v = d;
    l1 = cfg_m.zone_one_limit;
    l2 = cfg_m.zone_two_limit;
    l3 = cfg_m.zone_three_limit;
    l4 = cfg_m.zone_four_limit;
    if (v >= int'(cfg_m.zone_base) && v <= l1) return ZONE_ONE;
    if (v >= l1 - 1 && v <= l2) return ZONE_TWO;
    if (v >= l2 - 1 && v <= l3) return ZONE_THREE;
    if (v >= l3 - 1 && v <= l4) return ZONE_FOUR;
    return old;
  endfunction

  // advances the model by one event, returns 1 with the command for a tick
  function automatic bit step_decider(input osd_item_t it, output osd_result_t cmd);
    logic              near;
    logic              front_block;
    logic signed [7:0] h;
    steer_state_t      nxt;
    int                d;
    cmd = '0;
    case (it.req_type)
      REQ_SAMPLE: begin
        if (at_dest) begin
          state_now = ST_STOP;
        end else begin
          zone_l = zone_of(it.left_dist, zone_l);
          zone_m = zone_of(it.middle_dist, zone_m);
          zone_r = zone_of(it.right_dist, zone_r);
          near = it.back_dist <= cfg_m.back_near_limit;
          front_block = zone_m == ZONE_ONE || (zone_l == ZONE_ONE && zone_r == ZONE_ONE);
          h = head_err;
          nxt = state_now;
          if ((state_prev == ST_REVERSE || state_prev == ST_STOP) && near) begin
            nxt = ST_STOP;
          end else if (front_block && near) begin
            nxt = ST_STOP;
          end else if (front_block) begin
            rev_turn_left = !(zone_l > ZONE_ONE && zone_r == ZONE_ONE);
            nxt = ST_REVERSE;
          end else if (zone_l == ZONE_ONE) begin
            nxt = ST_FULL_RIGHT;
          end else if (zone_r == ZONE_ONE) begin
            nxt = ST_FULL_LEFT;
          end else if (zone_m == ZONE_TWO && zone_l > zone_r) begin
            nxt = ST_MID_LEFT;
          end else if (zone_m == ZONE_TWO) begin
            nxt = ST_MID_RIGHT;
          end else if (zone_m == ZONE_THREE && zone_l >= ZONE_TWO && zone_l < ZONE_FOUR &&
                       zone_m <= zone_r) begin
            nxt = ST_SLIGHT_RIGHT;
          end else if (zone_m == ZONE_THREE && zone_r >= ZONE_TWO && zone_r < ZONE_FOUR &&
                       zone_m < zone_l) begin
            nxt = ST_SLIGHT_LEFT;
          end else if (zone_m == ZONE_FOUR) begin
            // clear path: steer by heading, keep the state when far off
            if (h <= -1 && h >= -6) begin
              nxt = ST_MID_RIGHT;
            end else if (h <= -5 && h >= -10) begin
              nxt = ST_REVERSE;
              rev_turn_left = 1'b1;
            end else if (h >= 1 && h <= 6) begin
              nxt = ST_MID_LEFT;
            end else if (h >= 5 && h <= 10) begin
              nxt = ST_REVERSE;
              rev_turn_left = 1'b0;
            end else if (h == 0) begin
              nxt = ST_STRAIGHT;
            end
          end else begin
            nxt = ST_STRAIGHT;
          end
          state_now = nxt;
          state_prev = nxt;
        end
        return 1'b0;
      end
      REQ_GEO: begin
        fix_ok = it.geo_ok;
        if (it.geo_ok) begin
          d = $signed(it.compass_angle) - $signed(it.bearing_angle);
          if (d <= -10) d = d + 20;
          else if (d >= 10) d = 20 - d;
          head_err = d[7:0];
        end else begin
          head_err = '0;
        end
        at_dest = it.dest_distance <= cfg_m.arrive_distance;
        return 1'b0;
      end
      REQ_PAUSE: begin
        on_hold = 1'b1;
        return 1'b0;
      end
      REQ_RESUME: begin
        on_hold = 1'b0;
        return 1'b0;
      end
      REQ_TICK: begin
        cmd = {DIR_FWD, SPEED_HALT, STEER_CENTER, state_now};
        if (fix_ok && !on_hold) begin
          cmd.drive_speed = SPEED_CRAWL;
          case (state_now)
            ST_STOP: begin
              cmd.drive_dir = DIR_REV;
              cmd.drive_speed = SPEED_ESTOP;
            end
            ST_REVERSE: begin
              cmd.drive_dir = DIR_REV;
              cmd.steer = rev_turn_left ? STEER_HALF_LEFT : STEER_HALF_RIGHT;
            end
            ST_FULL_LEFT:    cmd.steer = STEER_HARD_LEFT;
            ST_FULL_RIGHT:   cmd.steer = STEER_HARD_RIGHT;
            ST_MID_LEFT:     cmd.steer = STEER_HALF_LEFT;
            ST_MID_RIGHT:    cmd.steer = STEER_HALF_RIGHT;
            ST_SLIGHT_LEFT:  cmd.steer = STEER_SOFT_LEFT;
            ST_SLIGHT_RIGHT: cmd.steer = STEER_SOFT_RIGHT;
            ST_STRAIGHT:     cmd.steer = STEER_CENTER;
            default:         cmd.drive_speed = SPEED_HALT;
          endcase
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic osd_item_t ev(input logic [2:0] rq, input logic [7:0] l, m, r, b,
                                   input logic ok, input logic [7:0] ca, da,
                                   input logic [15:0] dd);
    return osd_item_t'{rq, l, m, r, b, ok, ca, da, dd};
  endfunction

  task automatic add(input osd_item_t e, input bit fixed = 1'b0,
                     input osd_result_t want = '0);
    script.push_back('{e, fixed, want});
  endtask

  // distance near one of the current thresholds, or anywhere
  function automatic logic [7:0] pick_dist();
    int v;
    if ($urandom_range(99) < 40) return 8'($urandom);
    case ($urandom_range(5))
      0: v = cfg_m.zone_base;
      1: v = cfg_m.zone_one_limit;
      2: v = cfg_m.zone_two_limit;
      3: v = cfg_m.zone_three_limit;
      4: v = cfg_m.zone_four_limit;
      default: v = cfg_m.back_near_limit;
    endcase
    v = v + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_event(input osd_item_t it, input bit fixed = 1'b0,
                            input osd_result_t want = '0);
    osd_result_t cmd;
    if (gaps_on)
      while ($urandom_range(99) < GAP_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid         <= 1'b1;
    in_req_type      <= it.req_type;
    in_left_dist     <= it.left_dist;
    in_middle_dist   <= it.middle_dist;
    in_right_dist    <= it.right_dist;
    in_back_dist     <= it.back_dist;
    in_geo_ok        <= it.geo_ok;
    in_compass_angle <= it.compass_angle;
    in_bearing_angle <= it.bearing_angle;
    in_dest_distance <= it.dest_distance;
    do @(posedge clk); while (!in_ready);
    n_events++;
    if (step_decider(it, cmd)) pending_cmds.push_back(fixed ? want : cmd);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ZONE_BASE:   cfg_m.zone_base = data[7:0];
      CFG_ZONE_ONE:    cfg_m.zone_one_limit = data[7:0];
      CFG_ZONE_TWO:    cfg_m.zone_two_limit = data[7:0];
      CFG_ZONE_THREE:  cfg_m.zone_three_limit = data[7:0];
      CFG_ZONE_FOUR:   cfg_m.zone_four_limit = data[7:0];
      CFG_BACK_NEAR:   cfg_m.back_near_limit = data[7:0];
      CFG_ARRIVE_DIST: cfg_m.arrive_distance = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_cmd = {out_drive_dir, out_drive_speed, out_steer, out_steer_state};
      if (pending_cmds.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected command dir=%0d speed=%0d steer=%0d state=%0d", $time,
                   seen_cmd.drive_dir, seen_cmd.drive_speed, seen_cmd.steer,
                   seen_cmd.steer_state);
      end else begin
        due_cmd = pending_cmds.pop_front();
        n_cmds++;
        if (seen_cmd !== due_cmd) begin
          bad++;
          if (bad <= 10)
            $display("%0t: command %0d expected dir=%0d speed=%0d steer=%0d state=%0d, got %s",
                     $time, n_cmds, due_cmd.drive_dir, due_cmd.drive_speed, due_cmd.steer,
                     due_cmd.steer_state,
                     $sformatf("dir=%0d speed=%0d steer=%0d state=%0d", seen_cmd.drive_dir,
                               seen_cmd.drive_speed, seen_cmd.steer, seen_cmd.steer_state));
        end
      end
    end
    out_ready <= !gaps_on || $urandom_range(99) >= GAP_PCT;
  end

  initial begin
    osd_cfg_t  c;
    osd_item_t it;
    int        p, k, sel;

    // tick straight after reset, then gated ticks until a fix arrives
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0), 1'b1,
        {DIR_FWD, SPEED_HALT, STEER_CENTER, ST_STOP});
    add(ev(REQ_RESUME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0), 1'b1,
        {DIR_FWD, SPEED_HALT, STEER_CENTER, ST_STOP});
    add(ev(REQ_GEO, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'h00, 8'h00, 16'hFFFF));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0), 1'b1,
        {DIR_REV, SPEED_ESTOP, STEER_CENTER, ST_STOP});
    add(ev(REQ_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0), 1'b1,
        {DIR_FWD, SPEED_CRAWL, STEER_CENTER, ST_STRAIGHT});
    // middle blocked: reverse to the left, then to the right
    add(ev(REQ_SAMPLE, 8'd100, 8'd0, 8'd100, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd255, 8'd0, 8'd10, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    // rear blocked while reversing, then full, mid and slight turns
    add(ev(REQ_SAMPLE, 8'd100, 8'd100, 8'd100, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd10, 8'd50, 8'd50, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd255, 8'd30, 8'd5, 8'd21, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd255, 8'd30, 8'd45, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd50, 8'd50, 8'd255, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    // widest angle difference folds far outside the heading bands
    add(ev(REQ_GEO, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'h80, 8'h7F, 16'd31));
    add(ev(REQ_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_GEO, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hF8, 8'h00, 16'd100));
    add(ev(REQ_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    // lost fix at the destination, then pause and the unused codes
    add(ev(REQ_GEO, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h7F, 8'h80, 16'd30));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SAMPLE, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_PAUSE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 16'd0));
    add(ev(REQ_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 16'hFFFF));
    add(ev(REQ_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 16'hFFFF));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_event(script[i].ev, script[i].fixed, script[i].cmd);

    for (p = 0; p < PHASES; p++) begin
      gaps_on = (p != 4);
      if (p > 0) begin
        drain();
        case (p)
          1: c = '0;
          2: c = '1;
          3: c = osd_cfg_t'{RST_ZONE_BASE, RST_ZONE_ONE, RST_ZONE_TWO, RST_ZONE_THREE,
                            RST_ZONE_FOUR, RST_BACK_NEAR, RST_ARRIVE_DIST};
          5: begin
            c = osd_cfg_t'({$urandom, $urandom});
            c.arrive_distance = 16'($urandom_range(300));
          end
          default: begin
            c.zone_one_limit   = 8'($urandom_range(60, 5));
            c.zone_base        = 8'($urandom_range(c.zone_one_limit));
            c.zone_two_limit   = c.zone_one_limit + 8'($urandom_range(50, 3));
            c.zone_three_limit = c.zone_two_limit + 8'($urandom_range(50, 3));
            c.zone_four_limit  = 8'($urandom_range(255, c.zone_three_limit));
            c.back_near_limit  = 8'($urandom_range(80));
            c.arrive_distance  = 16'($urandom_range(200));
          end
        endcase
        write_reg(CFG_ZONE_BASE, {8'($urandom), c.zone_base});
        write_reg(CFG_ZONE_ONE, {8'($urandom), c.zone_one_limit});
        write_reg(CFG_ZONE_TWO, {8'($urandom), c.zone_two_limit});
        write_reg(CFG_ZONE_THREE, {8'($urandom), c.zone_three_limit});
        write_reg(CFG_ZONE_FOUR, {8'($urandom), c.zone_four_limit});
        write_reg(CFG_BACK_NEAR, {8'($urandom), c.back_near_limit});
        write_reg(CFG_ARRIVE_DIST, c.arrive_distance);
        if (p == 1) write_reg(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
        n_settings++;
      end
      for (k = 0; k < PHASE_EVENTS; k++) begin
        it.left_dist   = pick_dist();
        it.middle_dist = pick_dist();
        it.right_dist  = pick_dist();
        it.back_dist   = pick_dist();
        it.geo_ok      = $urandom_range(99) < 85;
        it.compass_angle = 8'($urandom);
        if ($urandom_range(99) < 70)
          it.bearing_angle = it.compass_angle + 8'($urandom_range(24)) - 8'd12;
        else
          it.bearing_angle = 8'($urandom);
        if ($urandom_range(99) < 15)
          it.dest_distance = cfg_m.arrive_distance + 16'($urandom_range(2)) - 16'd1;
        else
          it.dest_distance = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 36) it.req_type = REQ_SAMPLE;
        else if (sel < 66) it.req_type = REQ_TICK;
        else if (sel < 80) it.req_type = REQ_GEO;
        else if (sel < 84) it.req_type = REQ_PAUSE;
        else if (sel < 96) it.req_type = REQ_RESUME;
        else it.req_type = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        send_event(it);
      end
    end

    drain();
    $display("%0d events transferred, %0d commands compared, %0d register settings",
             n_events, n_cmds, n_settings);
    $display("%0d mismatches, %0d commands outstanding", bad, pending_cmds.size());
    if (bad == 0 && pending_cmds.size() == 0) begin
      $display("obstacle_steering_decider test passed");
    end else begin
      $display("obstacle_steering_decider test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("obstacle_steering_decider test failed");
    $finish;
  end

endmodule
